>>> hdl/blzd_pkg.sv
`default_nettype none
package blzd_pkg;

  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_LIMIT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DECODE_MODE  = 1'd1;

  localparam logic [31:0] OUTPUT_LIMIT_RESET = 32'd65536;
  localparam logic        DECODE_MODE_RESET  = 1'b1;

  localparam logic [7:0] CTRL_CLOSE     = 8'hE0;
  localparam logic [7:0] CTRL_LIT_FIRST = 8'hE1;
  localparam logic [7:0] CTRL_SHORT_MIN = 8'h20;
  localparam logic [4:0] LOW_MASK       = 5'h1F;
  localparam logic [5:0] LONG_LEN_BASE  = 6'd4;
  localparam logic [5:0] SHORT_LEN_BASE = 6'd2;
  localparam logic [31:0] MIN_IN_BYTES  = 32'd4;
  localparam logic [15:0] END_PAIR      = 16'hE0E0;

  localparam logic [1:0] KIND_DATA   = 2'd0;
  localparam logic [1:0] KIND_ACCEPT = 2'd1;
  localparam logic [1:0] KIND_REJECT = 2'd2;

  typedef enum logic [1:0] {
    PH_CTRL  = 2'd0,
    PH_LIT   = 2'd1,
    PH_FIRST = 2'd2,
    PH_HIGH  = 2'd3
  } phase_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       stream_end;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  data_byte;
    logic [31:0] produced_count;
    logic [31:0] consumed_count;
    logic        run_last;
  } out_item_t;

  typedef struct packed {
    logic load;
    logic parse;
    logic write;
    logic status;
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic copy_go;
    logic copy_last;
    logic item_end;
  } sts_t;

endpackage
`default_nettype wire

>>> hdl/blzd_ctrl.sv
`default_nettype none
module blzd_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire blzd_pkg::sts_t sts,
  output blzd_pkg::cmd_t     cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_PARSE,
    S_READ,
    S_WRITE,
    S_STATUS
  } state_t;

  state_t state, state_next;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cmd = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          state_next = S_PARSE;
        end
      end
      S_PARSE: begin
        if (sts.out_free) begin
          cmd.parse = 1'b1;
          if (sts.copy_go) state_next = S_READ;
          else if (sts.item_end) state_next = S_STATUS;
          else state_next = S_IDLE;
        end
      end
      S_READ: begin
        state_next = S_WRITE;
      end
      S_WRITE: begin
        if (sts.out_free) begin
          cmd.write = 1'b1;
          if (!sts.copy_last) state_next = S_READ;
          else if (sts.item_end) state_next = S_STATUS;
          else state_next = S_IDLE;
        end
      end
      S_STATUS: begin
        if (sts.out_free) begin
          cmd.status = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule
`default_nettype wire

>>> hdl/blzd_dp.sv
`default_nettype none
module blzd_dp #(
  parameter int unsigned BLOCK_BYTES = 8192
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire blzd_pkg::in_item_t            in_data,
  input  wire logic                          cfg_we,
  input  wire logic [blzd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [31:0]                   cfg_data,
  input  wire blzd_pkg::cmd_t                cmd,
  output blzd_pkg::sts_t                     sts,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output blzd_pkg::out_item_t                out_data
);

  localparam int unsigned AW = $clog2(BLOCK_BYTES);
  localparam int unsigned FW = $clog2(BLOCK_BYTES + 1);
  localparam logic [31:0] FULL_BLOCK = 32'(BLOCK_BYTES);

  logic [31:0] output_limit;
  logic        decode_mode;

  logic [7:0]  cur_byte;
  logic        cur_end;
  logic [31:0] out_total;
  logic [FW-1:0] block_fill;
  logic [FW-1:0] prior_block_size;
  logic [FW-1:0] older_block_size;
  logic [1:0]  closed_blocks;
  blzd_pkg::phase_t parse_phase;
  logic [4:0]  literal_left;
  logic [7:0]  held_control;
  logic [7:0]  held_low;
  logic [31:0] in_total;
  logic [15:0] recent_pair;
  logic        failed;
  logic [FW-1:0] copy_src;
  logic [5:0]  copy_left;

  logic [7:0] store [BLOCK_BYTES];
  logic [7:0] rd_data;
  logic       mem_we;
  logic [7:0] mem_wdata;

  logic        out_free;
  logic [31:0] fill_w;
  logic        lit_ok;
  logic        is_short;
  logic [5:0]  m_len;
  logic [13:0] back_dist;
  logic [15:0] off;
  logic [31:0] room;
  logic        ref_bad;
  logic        room_bad;
  logic [FW-1:0] m_src;
  logic        match_tok;
  logic        copy_go;
  logic        lit_put;
  logic        end_ok;
  logic        out_load;

  assign fill_w   = 32'(block_fill);
  assign out_free = !out_valid || !out_stall;
  assign lit_ok   = (out_total < output_limit) && (fill_w < FULL_BLOCK);
  assign is_short = (held_control >= blzd_pkg::CTRL_SHORT_MIN);
  assign back_dist = {held_control[4:0], cur_byte} + 14'd1;
  assign off      = {cur_byte, held_low};
  assign m_len    = is_short ? (6'(held_control[7:5]) + blzd_pkg::SHORT_LEN_BASE)
                             : (6'(held_control[4:0] & blzd_pkg::LOW_MASK)
                                + blzd_pkg::LONG_LEN_BASE);
  assign ref_bad  = is_short ? (32'(back_dist) > fill_w) : (32'(off) >= fill_w);
  assign m_src    = is_short ? FW'(fill_w - 32'(back_dist)) : FW'(off);
  assign room     = output_limit - out_total;
  assign room_bad = (32'(m_len) > room) || (fill_w + 32'(m_len) > FULL_BLOCK);
  assign match_tok = ((parse_phase == blzd_pkg::PH_FIRST) && is_short)
                   || (parse_phase == blzd_pkg::PH_HIGH);
  assign copy_go  = !failed && match_tok && !ref_bad && !room_bad;
  assign lit_put  = cmd.parse && !failed && (parse_phase == blzd_pkg::PH_LIT) && lit_ok;
  assign out_load = ((lit_put || cmd.write) && decode_mode) || cmd.status;

  assign end_ok = !failed && (parse_phase == blzd_pkg::PH_CTRL)
                  && (in_total >= blzd_pkg::MIN_IN_BYTES)
                  && (recent_pair == blzd_pkg::END_PAIR) && (block_fill == '0)
                  && (closed_blocks >= 2'd2) && (prior_block_size == '0)
                  && (older_block_size != '0)
                  && (32'(older_block_size) <= FULL_BLOCK)
                  && (out_total != '0) && (output_limit != '0)
                  && (!decode_mode || (out_total == output_limit));

  assign sts.out_free  = out_free;
  assign sts.copy_go   = copy_go;
  assign sts.copy_last = (copy_left == 6'd1);
  assign sts.item_end  = cur_end;

  assign mem_we    = lit_put || cmd.write;
  assign mem_wdata = cmd.write ? rd_data : cur_byte;

  always_ff @(posedge clk) begin
    if (mem_we) store[block_fill[AW-1:0]] <= mem_wdata;
    rd_data <= store[copy_src[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      output_limit     <= blzd_pkg::OUTPUT_LIMIT_RESET;
      decode_mode      <= blzd_pkg::DECODE_MODE_RESET;
      out_valid        <= 1'b0;
      out_total        <= '0;
      block_fill       <= '0;
      prior_block_size <= '0;
      older_block_size <= '0;
      closed_blocks    <= '0;
      parse_phase      <= blzd_pkg::PH_CTRL;
      literal_left     <= '0;
      held_control     <= '0;
      held_low         <= '0;
      in_total         <= '0;
      recent_pair      <= '0;
      failed           <= 1'b0;
      copy_src         <= '0;
      copy_left        <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          blzd_pkg::CFG_OUTPUT_LIMIT: output_limit <= cfg_data;
          blzd_pkg::CFG_DECODE_MODE:  decode_mode  <= cfg_data[0];
          default: ;
        endcase
      end
      if (out_load) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;

      if (cmd.load) begin
        cur_byte    <= in_data.in_byte;
        cur_end     <= in_data.stream_end;
        recent_pair <= {recent_pair[7:0], in_data.in_byte};
        if (in_total != '1) in_total <= in_total + 32'd1;
        if (in_total == '0 && in_data.in_byte < blzd_pkg::CTRL_LIT_FIRST) failed <= 1'b1;
      end

      if (cmd.parse && !failed) begin
        case (parse_phase)
          blzd_pkg::PH_CTRL: begin
            if (cur_byte >= blzd_pkg::CTRL_LIT_FIRST) begin
              literal_left <= cur_byte[4:0];
              parse_phase  <= blzd_pkg::PH_LIT;
            end else if (cur_byte == blzd_pkg::CTRL_CLOSE) begin
              if (closed_blocks >= 2'd2 && 32'(older_block_size) != FULL_BLOCK) begin
                failed <= 1'b1;
              end else begin
                older_block_size <= prior_block_size;
                prior_block_size <= block_fill;
                if (closed_blocks < 2'd2) closed_blocks <= closed_blocks + 2'd1;
                block_fill <= '0;
              end
            end else begin
              held_control <= cur_byte;
              parse_phase  <= blzd_pkg::PH_FIRST;
            end
          end
          blzd_pkg::PH_LIT: begin
            if (!lit_ok) begin
              failed <= 1'b1;
            end else begin
              block_fill <= block_fill + FW'(1);
              out_total  <= out_total + 32'd1;
              if (decode_mode) begin
                out_data  <= '{kind: blzd_pkg::KIND_DATA, data_byte: cur_byte,
                               produced_count: '0, consumed_count: '0,
                               run_last: !cur_end};
              end
            end
            if (literal_left > 5'd0) literal_left <= literal_left - 5'd1;
            if (literal_left <= 5'd1) parse_phase <= blzd_pkg::PH_CTRL;
          end
          blzd_pkg::PH_FIRST: begin
            if (is_short) begin
              parse_phase <= blzd_pkg::PH_CTRL;
            end else begin
              held_low    <= cur_byte;
              parse_phase <= blzd_pkg::PH_HIGH;
            end
          end
          default: begin
            parse_phase <= blzd_pkg::PH_CTRL;
          end
        endcase
        if (match_tok) begin
          if (ref_bad || room_bad) begin
            failed <= 1'b1;
          end else begin
            copy_src  <= m_src;
            copy_left <= m_len;
          end
        end
      end

      if (cmd.write) begin
        block_fill <= block_fill + FW'(1);
        out_total  <= out_total + 32'd1;
        copy_src   <= copy_src + FW'(1);
        copy_left  <= copy_left - 6'd1;
        if (decode_mode) begin
          out_data  <= '{kind: blzd_pkg::KIND_DATA, data_byte: rd_data,
                         produced_count: '0, consumed_count: '0,
                         run_last: (copy_left == 6'd1) && !cur_end};
        end
      end

      if (cmd.status) begin
        if (end_ok) begin
          out_data <= '{kind: blzd_pkg::KIND_ACCEPT, data_byte: '0,
                        produced_count: out_total, consumed_count: in_total,
                        run_last: 1'b1};
        end else begin
          out_data <= '{kind: blzd_pkg::KIND_REJECT, data_byte: '0,
                        produced_count: '0, consumed_count: '0, run_last: 1'b1};
        end
        out_total        <= '0;
        block_fill       <= '0;
        prior_block_size <= '0;
        older_block_size <= '0;
        closed_blocks    <= '0;
        parse_phase      <= blzd_pkg::PH_CTRL;
        literal_left     <= '0;
        held_control     <= '0;
        held_low         <= '0;
        in_total         <= '0;
        recent_pair      <= '0;
        failed           <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

>>> hdl/block_lz_payload_decoder.sv
// block lz payload decoder: one compressed byte enters per input beat and
// decoded bytes (in decode mode) leave one per output beat, then an accept or
// reject beat on the byte flagged stream_end (with totals on accept).
// input: in_valid / in_stall with in_data; stall is high while an item is
// being worked on. output: out_valid / out_stall with out_data held in one
// output register while stalled. config: cfg_valid / cfg_ready (always
// ready) with cfg_index and cfg_data, written between items.
// flow: each byte is loaded and then parsed; a match (3..35 bytes) then
// copies each byte as a registered read of the block store followed by its
// write; stream end adds a status step.
// a stalled output holds the controller in place, so no result is lost.
// reset (rst, synchronous) returns the parse state, counts and config to
// their defaults; the block store is not cleared and needs no sweep.
`default_nettype none
module block_lz_payload_decoder #(
  parameter int unsigned BLOCK_BYTES = 8192
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire blzd_pkg::in_item_t            in_data,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output blzd_pkg::out_item_t                out_data,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [blzd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [31:0]                   cfg_data
);

  blzd_pkg::cmd_t cmd;
  blzd_pkg::sts_t sts;

  assign cfg_ready = 1'b1;

  blzd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  blzd_dp #(
    .BLOCK_BYTES (BLOCK_BYTES)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

>>> verif/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned BLK = 8192;

  typedef struct {
    logic [7:0] b;
    bit         e;
    bit         typed;
    logic [1:0] k;
  } dir_row_t;

  typedef struct {
    logic [31:0] lim;
    bit          mode;
  } setting_t;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          in_valid = 1'b0;
  logic                          in_stall;
  blzd_pkg::in_item_t            in_data = '0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  blzd_pkg::out_item_t           out_data;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [blzd_pkg::CFG_IDX_W-1:0] cfg_index = blzd_pkg::CFG_OUTPUT_LIMIT;
  logic [31:0]                   cfg_data = '0;

  block_lz_payload_decoder #(.BLOCK_BYTES(BLK)) dut (
    .clk, .rst, .in_valid, .in_stall, .in_data, .out_valid, .out_stall, .out_data,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    #100ms;
    $display("Verification failed");
    $finish;
  end

  // decoder state mirror
  logic [7:0]  hist_mem [BLK];
  logic [31:0] lim_r;
  bit          mode_r;
  int unsigned out_tot, fill, prior_sz, older_sz, closed_n, lit_left, in_tot;
  blzd_pkg::phase_t ph;
  logic [7:0]  hold_ctrl, hold_lo;
  logic [15:0] last_pair;
  bit          bad;

  blzd_pkg::out_item_t step_res[$];
  blzd_pkg::out_item_t want_q[$];
  blzd_pkg::in_item_t  stim_q[$];
  int        errs = 0;
  int        items_sent = 0;
  bit        tx_quiet = 1'b0, rx_quiet = 1'b0;
  int        rx_hold = 0;

  function automatic void clear_stream();
    out_tot = 0; fill = 0; prior_sz = 0; older_sz = 0; closed_n = 0;
    ph = blzd_pkg::PH_CTRL; lit_left = 0; hold_ctrl = '0; hold_lo = '0;
    in_tot = 0; last_pair = '0; bad = 1'b0;
  endfunction

  function automatic void emit_res(logic [1:0] k, logic [7:0] d, logic [31:0] p,
                                   logic [31:0] c);
    blzd_pkg::out_item_t r;
    r.kind = k; r.data_byte = d; r.produced_count = p; r.consumed_count = c;
    r.run_last = 1'b0;
    step_res.push_back(r);
  endfunction

  function automatic void put_out(logic [7:0] b);
    if (out_tot >= lim_r || fill >= BLK) begin
      bad = 1'b1;
      return;
    end
    hist_mem[fill] = b;
    fill++;
    out_tot++;
    if (mode_r) emit_res(blzd_pkg::KIND_DATA, b, 0, 0);
  endfunction

  function automatic void copy_run(int unsigned src, int unsigned len);
    if (len > lim_r - out_tot || fill + len > BLK) begin
      bad = 1'b1;
      return;
    end
    for (int unsigned i = 0; i < len; i++)
      put_out((src + i < BLK) ? hist_mem[src + i] : 8'h00);
  endfunction

  function automatic void close_blk();
    if (closed_n >= 2 && older_sz != BLK) begin
      bad = 1'b1;
      return;
    end
    older_sz = prior_sz;
    prior_sz = fill;
    if (closed_n < 2) closed_n++;
    fill = 0;
  endfunction

  function automatic void decode_byte(logic [7:0] b);
    int unsigned len, back, off;
    case (ph)
      blzd_pkg::PH_CTRL: begin
        if (b >= blzd_pkg::CTRL_LIT_FIRST) begin
          lit_left = b - blzd_pkg::CTRL_CLOSE;
          ph = blzd_pkg::PH_LIT;
        end else if (b == blzd_pkg::CTRL_CLOSE) begin
          close_blk();
        end else begin
          hold_ctrl = b;
          ph = blzd_pkg::PH_FIRST;
        end
      end
      blzd_pkg::PH_LIT: begin
        put_out(b);
        if (lit_left > 0) lit_left--;
        if (lit_left == 0) ph = blzd_pkg::PH_CTRL;
      end
      blzd_pkg::PH_FIRST: begin
        if (hold_ctrl >= blzd_pkg::CTRL_SHORT_MIN) begin
          ph = blzd_pkg::PH_CTRL;
          len = (hold_ctrl >> 5) + blzd_pkg::SHORT_LEN_BASE;
          back = {(hold_ctrl & blzd_pkg::LOW_MASK), b} + 1;
          if (back > fill) bad = 1'b1;
          else copy_run(fill - back, len);
        end else begin
          hold_lo = b;
          ph = blzd_pkg::PH_HIGH;
        end
      end
      default: begin
        ph = blzd_pkg::PH_CTRL;
        len = (hold_ctrl & blzd_pkg::LOW_MASK) + blzd_pkg::LONG_LEN_BASE;
        off = {b, hold_lo};
        if (off >= fill) bad = 1'b1;
        else copy_run(off, len);
      end
    endcase
  endfunction

  function automatic void predict_item(blzd_pkg::in_item_t it);
    bit ok;
    step_res.delete();
    if (in_tot == 0 && it.in_byte < blzd_pkg::CTRL_LIT_FIRST) bad = 1'b1;
    if (in_tot != 32'hFFFF_FFFF) in_tot++;
    last_pair = {last_pair[7:0], it.in_byte};
    if (!bad) decode_byte(it.in_byte);
    if (it.stream_end) begin
      ok = !bad && ph == blzd_pkg::PH_CTRL && in_tot >= blzd_pkg::MIN_IN_BYTES &&
           last_pair == blzd_pkg::END_PAIR &&
           fill == 0 && closed_n >= 2 && prior_sz == 0 && older_sz != 0 &&
           older_sz <= BLK && out_tot != 0 && lim_r != 0 &&
           (!mode_r || out_tot == lim_r);
      if (ok) emit_res(blzd_pkg::KIND_ACCEPT, 8'h00, out_tot, in_tot);
      else emit_res(blzd_pkg::KIND_REJECT, 8'h00, 0, 0);
      clear_stream();
    end
    if (step_res.size() > 0) step_res[$].run_last = 1'b1;
  endfunction

  // output side: random stall per beat, compare with oldest expectation
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      rx_hold = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (want_q.size() == 0) begin
          $error("unexpected result beat kind=%0d", out_data.kind);
          errs++;
        end else begin
          blzd_pkg::out_item_t w;
          w = want_q.pop_front();
          if (w.kind !== out_data.kind) begin
            $error("kind: expected %0d actual %0d", w.kind, out_data.kind); errs++;
          end
          if (w.data_byte !== out_data.data_byte) begin
            $error("data_byte: expected %0h actual %0h", w.data_byte, out_data.data_byte);
            errs++;
          end
          if (w.produced_count !== out_data.produced_count) begin
            $error("produced_count: expected %0d actual %0d", w.produced_count,
                   out_data.produced_count);
            errs++;
          end
          if (w.consumed_count !== out_data.consumed_count) begin
            $error("consumed_count: expected %0d actual %0d", w.consumed_count,
                   out_data.consumed_count);
            errs++;
          end
          if (w.run_last !== out_data.run_last) begin
            $error("run_last: expected %0d actual %0d", w.run_last, out_data.run_last);
            errs++;
          end
        end
        rx_hold = rx_quiet ? 0 : $urandom_range(0, 18);
      end else if (rx_hold > 0) begin
        rx_hold--;
      end
      out_stall <= (rx_hold != 0);
    end
  end

  task automatic send_item(blzd_pkg::in_item_t it, bit typed, logic [1:0] k);
    int gap;
    gap = tx_quiet ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_stall);
    predict_item(it);
    if (typed) begin
      step_res[$].kind = k;
      step_res[$].data_byte = '0;
      step_res[$].produced_count = '0;
      step_res[$].consumed_count = '0;
    end
    foreach (step_res[i]) want_q.push_back(step_res[i]);
    items_sent++;
  endtask

  task automatic drain(int extra);
    in_valid <= 1'b0;
    while (want_q.size() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  task automatic cfg_write(logic [blzd_pkg::CFG_IDX_W-1:0] idx, logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == blzd_pkg::CFG_OUTPUT_LIMIT) lim_r = val;
    else mode_r = val[0];
  endtask

  function automatic void push_byte(logic [7:0] b);
    blzd_pkg::in_item_t it;
    it.in_byte = b;
    it.stream_end = 1'b0;
    stim_q.push_back(it);
  endfunction

  // one block of sz decoded bytes, tokens chosen at random
  function automatic void gen_block(int unsigned sz, bit favour_long);
    int unsigned f = 0, r, n, len, back, off, pick;
    while (f < sz) begin
      r = sz - f;
      pick = favour_long ? 2 : $urandom_range(0, 2);
      if (f > 0 && pick == 2 && r >= 4) begin
        len = $urandom_range(4, (r < 35) ? r : 35);
        off = $urandom_range(0, f - 1);
        push_byte(8'(len - blzd_pkg::LONG_LEN_BASE));
        push_byte(off[7:0]);
        push_byte(off[15:8]);
        f += len;
      end else if (f > 0 && pick == 1 && r >= 3) begin
        len = $urandom_range(3, (r < 8) ? r : 8);
        back = $urandom_range(1, (f < BLK) ? f : BLK);
        push_byte(8'(((len - blzd_pkg::SHORT_LEN_BASE) << 5) | ((back - 1) >> 8)));
        push_byte(8'(back - 1));
        f += len;
      end else begin
        n = $urandom_range(1, (r < 31) ? r : 31);
        push_byte(8'(blzd_pkg::CTRL_CLOSE + n));
        repeat (n) push_byte(8'($urandom_range(0, 255)));
        f += n;
      end
    end
    push_byte(blzd_pkg::CTRL_CLOSE);
  endfunction

  task automatic run_stream(int unsigned sz, bit big);
    int unsigned cut;
    stim_q.delete();
    if ($urandom_range(0, 9) == 0) begin
      // noise
      repeat ($urandom_range(1, 10)) push_byte(8'($urandom_range(0, 255)));
    end else begin
      if (big) gen_block(BLK, 1'b1);
      gen_block(sz, 1'b0);
      push_byte(blzd_pkg::CTRL_CLOSE);
      case ($urandom_range(0, 7))
        0: stim_q[$urandom_range(0, stim_q.size() - 1)].in_byte = 8'($urandom_range(0, 255));
        1: begin
          cut = $urandom_range(1, stim_q.size() - 1);
          while (stim_q.size() > cut) void'(stim_q.pop_back());
        end
        2: push_byte(blzd_pkg::CTRL_CLOSE);
        default: ;
      endcase
    end
    stim_q[$].stream_end = 1'b1;
    tx_quiet = ($urandom_range(0, 3) == 0);
    rx_quiet = ($urandom_range(0, 3) == 0);
    foreach (stim_q[i]) send_item(stim_q[i], 1'b0, blzd_pkg::KIND_DATA);
  endtask

  dir_row_t dir_tab [25];
  setting_t plan [9];

  initial begin
    int unsigned sz, n_streams;
    lim_r = blzd_pkg::OUTPUT_LIMIT_RESET;
    mode_r = blzd_pkg::DECODE_MODE_RESET;
    clear_stream();
    dir_tab = '{
      // bad first byte
      '{8'h00, 1, 1, blzd_pkg::KIND_REJECT},
      // literal stream, size short of the limit
      '{8'hE1, 0, 0, blzd_pkg::KIND_DATA}, '{8'hFF, 0, 0, blzd_pkg::KIND_DATA},
      '{blzd_pkg::CTRL_CLOSE, 0, 0, blzd_pkg::KIND_DATA},
      '{blzd_pkg::CTRL_CLOSE, 1, 1, blzd_pkg::KIND_REJECT},
      // overlapping short match of one back
      '{8'hE2, 0, 0, blzd_pkg::KIND_DATA}, '{8'h00, 0, 0, blzd_pkg::KIND_DATA},
      '{8'h80, 0, 0, blzd_pkg::KIND_DATA},
      '{blzd_pkg::CTRL_SHORT_MIN, 0, 0, blzd_pkg::KIND_DATA},
      '{8'h00, 0, 0, blzd_pkg::KIND_DATA},
      '{blzd_pkg::CTRL_CLOSE, 0, 0, blzd_pkg::KIND_DATA},
      '{blzd_pkg::CTRL_CLOSE, 1, 1, blzd_pkg::KIND_REJECT},
      // longest long match, overlapping
      '{8'hE1, 0, 0, blzd_pkg::KIND_DATA}, '{8'hAA, 0, 0, blzd_pkg::KIND_DATA},
      '{8'h1F, 0, 0, blzd_pkg::KIND_DATA}, '{8'h00, 0, 0, blzd_pkg::KIND_DATA},
      '{8'h00, 0, 0, blzd_pkg::KIND_DATA},
      '{blzd_pkg::CTRL_CLOSE, 0, 0, blzd_pkg::KIND_DATA},
      '{blzd_pkg::CTRL_CLOSE, 1, 1, blzd_pkg::KIND_REJECT},
      // distance beyond the block fill
      '{8'hE1, 0, 0, blzd_pkg::KIND_DATA}, '{8'h01, 0, 0, blzd_pkg::KIND_DATA},
      '{8'hDF, 0, 0, blzd_pkg::KIND_DATA}, '{8'hFF, 0, 0, blzd_pkg::KIND_DATA},
      '{blzd_pkg::CTRL_CLOSE, 0, 0, blzd_pkg::KIND_DATA},
      '{blzd_pkg::CTRL_CLOSE, 1, 1, blzd_pkg::KIND_REJECT}
    };
    plan = '{
      '{32'd1, 1'b1}, '{32'hFFFF_FFFF, 1'b0}, '{32'd45, 1'b1}, '{32'd150, 1'b0},
      '{32'd12, 1'b1}, '{32'hFFFF_FFFF, 1'b1}, '{32'd1, 1'b0}, '{32'd90, 1'b1},
      '{32'd3, 1'b1}
    };

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_tab[i]) begin
      blzd_pkg::in_item_t it;
      it.in_byte = dir_tab[i].b;
      it.stream_end = dir_tab[i].e;
      send_item(it, dir_tab[i].typed, dir_tab[i].k);
    end

    for (int p = 0; items_sent < 405; p++) begin
      setting_t s;
      s = plan[p % 9];
      drain(100);
      cfg_write(blzd_pkg::CFG_OUTPUT_LIMIT, s.lim);
      cfg_write(blzd_pkg::CFG_DECODE_MODE, s.mode);
      cfg_valid <= 1'b0;
      n_streams = $urandom_range(2, 4);
      for (int k = 0; k < n_streams; k++) begin
        if (s.mode && s.lim <= 200 && $urandom_range(0, 4) != 0)
          sz = s.lim;
        else
          sz = $urandom_range(1, (s.lim < 60) ? s.lim : 60);
        run_stream(sz, 1'b0);
        if (p == 2 && k == 0) drain(0);
      end
    end

    drain(100);
    if (errs == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

>>> block_lz_payload_decoder.f
hdl/blzd_pkg.sv
hdl/blzd_ctrl.sv
hdl/blzd_dp.sv
hdl/block_lz_payload_decoder.sv
verif/tb.sv
